>>> src/rrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types, codes and the microcode program of the raster canvas.
// ----------------------------------------------------------------------------
package rrc_pkg;

    // Request codes.
    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    // Rectangle kinds and the fixed-point unit (eight fraction bits).
    localparam logic [7:0] KIND_FILLED  = 8'h52;
    localparam logic [7:0] KIND_OUTLINE = 8'h72;
    localparam int         FRAC_BITS    = 8;
    localparam int         ONE_UNIT     = 256;

    // Microcode step addresses.
    localparam int          UPC_W   = 4;
    localparam logic [3:0]  U_IDLE  = 4'd0;
    localparam logic [3:0]  U_DISP  = 4'd1;
    localparam logic [3:0]  U_DRAW  = 4'd2;
    localparam logic [3:0]  U_READ  = 4'd3;
    localparam logic [3:0]  U_CLEAR = 4'd4;
    localparam logic [3:0]  U_NOP   = 4'd5;
    localparam logic [3:0]  U_ROW   = 4'd6;
    localparam logic [3:0]  U_COL   = 4'd7;
    localparam logic [3:0]  U_NEXT  = 4'd8;
    localparam logic [3:0]  U_FIN   = 4'd9;
    localparam logic [3:0]  U_REJ   = 4'd10;
    localparam logic [3:0]  U_RDOUT = 4'd11;

    // Branch conditions.
    localparam logic [2:0] C_ALWAYS  = 3'd0;
    localparam logic [2:0] C_START   = 3'd1;
    localparam logic [2:0] C_REQ     = 3'd2;
    localparam logic [2:0] C_REJECT  = 3'd3;
    localparam logic [2:0] C_ROW_END = 3'd4;
    localparam logic [2:0] C_COL_END = 3'd5;

    // Result kinds issued by a step.
    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_OK   = 2'd1;
    localparam logic [1:0] EM_REJ  = 2'd2;
    localparam logic [1:0] EM_READ = 2'd3;

    // One control word of the program.
    typedef struct packed {
        logic [2:0]       cond;
        logic [UPC_W-1:0] tgt_t;
        logic [UPC_W-1:0] tgt_f;
        logic             ld_draw;
        logic             ld_clear;
        logic             row_flags;
        logic             wr_cell;
        logic             next_row;
        logic             mem_rd;
        logic [1:0]       emit;
    } t_uword;

    // Status flags that the datapath hands to the sequencer.
    typedef struct packed {
        logic       start;
        logic       reject;
        logic       row_end;
        logic       col_end;
        logic [1:0] req;
    } t_flags;

    // The program ROM. Dispatch on the request adds the request code to U_DRAW.
    function automatic t_uword uword(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{cond: C_ALWAYS, tgt_t: U_IDLE, tgt_f: U_IDLE, emit: EM_NONE,
              default: 1'b0};
        unique case (pc)
            U_IDLE: begin
                w.cond  = C_START;
                w.tgt_t = U_DISP;
                w.tgt_f = U_IDLE;
            end
            U_DISP: begin
                w.cond  = C_REQ;
                w.tgt_t = U_DRAW;
            end
            U_DRAW: begin
                w.cond    = C_REJECT;
                w.tgt_t   = U_REJ;
                w.tgt_f   = U_ROW;
                w.ld_draw = 1'b1;
            end
            U_READ: begin
                w.tgt_t  = U_RDOUT;
                w.mem_rd = 1'b1;
            end
            U_CLEAR: begin
                w.tgt_t    = U_ROW;
                w.ld_clear = 1'b1;
            end
            U_NOP: begin
                w.emit = EM_OK;
            end
            U_ROW: begin
                w.cond      = C_ROW_END;
                w.tgt_t     = U_FIN;
                w.tgt_f     = U_COL;
                w.row_flags = 1'b1;
            end
            U_COL: begin
                w.cond    = C_COL_END;
                w.tgt_t   = U_NEXT;
                w.tgt_f   = U_COL;
                w.wr_cell = 1'b1;
            end
            U_NEXT: begin
                w.tgt_t    = U_ROW;
                w.next_row = 1'b1;
            end
            U_FIN: begin
                w.emit = EM_OK;
            end
            U_REJ: begin
                w.emit = EM_REJ;
            end
            U_RDOUT: begin
                w.emit = EM_READ;
            end
            default: begin
                w.tgt_t = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> src/rectangle_raster_canvas_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_raster_canvas_top
// Character canvas with clear, rectangle draw and cell read requests.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Busy stays
// high until the request is finished, and one result (o_status, o_cell_char)
// is then shown for exactly one cycle with o_done high; the receiver cannot
// stall it, and the next request may be taken at the edge that ends it.
// Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with
// i_cfg_index and i_cfg_data. The user must issue them while the block is
// idle; the block itself does not enforce this. A read goes through dispatch,
// the registered RAM read and the result step. A clear or draw runs the cell
// loop over ew by eh cells, ew and eh being the configured width and height
// clipped to MAX_DIM; a rejected draw answers without entering the loop. The
// cell loop writes one canvas cell per cycle through the single RAM write
// port, with a row step before and a next-row step after the cells of each
// row.
// Reset sets the size registers to 256 by 256 and the background to a space.
// The canvas memory is not cleared; a clear request must write it first.
// ----------------------------------------------------------------------------
module rectangle_raster_canvas_top import rrc_pkg::*; #(
    parameter int MAX_DIM = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_rect_kind,
    input  logic signed [17:0] i_rect_x,
    input  logic signed [17:0] i_rect_y,
    input  logic signed [17:0] i_rect_w,
    input  logic signed [17:0] i_rect_h,
    input  logic [7:0]         i_paint_char,
    input  logic [7:0]         i_read_col,
    input  logic [7:0]         i_read_row,
    // Configuration channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    // Result channel.
    output logic               o_done,
    output logic               o_status,
    output logic [7:0]         o_cell_char
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int GW    = (DW + FRAC_BITS + 1 > 20) ? DW + FRAC_BITS + 1 : 20;

    // Configuration registers.
    logic [8:0] r_cfg_w;
    logic [8:0] r_cfg_h;
    logic [7:0] r_bg;

    // Latched request.
    logic [1:0]         r_req;
    logic [7:0]         r_kind;
    logic signed [17:0] r_x;
    logic signed [17:0] r_y;
    logic signed [17:0] r_w;
    logic signed [17:0] r_h;
    logic [7:0]         r_paint;
    logic [7:0]         r_rcol;
    logic [7:0]         r_rrow;

    // Raster datapath.
    logic [DW-1:0]      r_row;
    logic [DW-1:0]      r_col;
    logic [AW-1:0]      r_base;
    logic               r_mode_clear;
    logic               r_outline;
    logic signed [GW-1:0] r_xl, r_xr, r_xil, r_xir;
    logic signed [GW-1:0] r_yl, r_yb, r_yil, r_yib;
    logic               r_row_in;
    logic               r_row_inner;

    // Result registers.
    logic               r_done;
    logic               r_status;
    logic [7:0]         r_cell;

    t_uword             uw;
    t_flags             flags;
    logic               idle;
    logic               accept;
    logic [DW-1:0]      ew;
    logic [DW-1:0]      eh;
    logic signed [GW-1:0] px;
    logic signed [GW-1:0] py;
    logic               col_in;
    logic               col_inner;
    logic               hit;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_lin;
    logic               rd_in_range;
    logic [7:0]         rd_data;
    logic               reject;

    assign busy        = !idle;
    assign accept      = start && idle;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_cell_char = r_cell;

    // Effective canvas size, clipped to the store.
    assign ew = (int'(r_cfg_w) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_cfg_w);
    assign eh = (int'(r_cfg_h) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_cfg_h);

    // A draw is rejected for an unknown kind or a size not above zero.
    assign reject = ((r_kind != KIND_FILLED) && (r_kind != KIND_OUTLINE)) ||
                    (r_w <= 18'sd0) || (r_h <= 18'sd0);

    // Flags and sequencer.
    assign flags = '{start: start, reject: reject, row_end: (r_row == eh),
                     col_end: (r_col == ew), req: r_req};

    rrc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_idle  (idle)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 9'd256;
            r_cfg_h <= 9'd256;
            r_bg    <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_BG:     r_bg    <= i_cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Latch the request fields when a request is taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_kind  <= i_rect_kind;
            r_x     <= i_rect_x;
            r_y     <= i_rect_y;
            r_w     <= i_rect_w;
            r_h     <= i_rect_h;
            r_paint <= i_paint_char;
            r_rcol  <= i_read_col;
            r_rrow  <= i_read_row;
        end
    end

    // Cell position in fixed point.
    assign px = $signed({{(GW - DW - FRAC_BITS){1'b0}}, r_col, {FRAC_BITS{1'b0}}});
    assign py = $signed({{(GW - DW - FRAC_BITS){1'b0}}, r_row, {FRAC_BITS{1'b0}}});

    // Column tests against the closed rectangle and its inner part.
    assign col_in    = (px >= r_xl) && (px <= r_xr);
    assign col_inner = (px >= r_xil) && (px <= r_xir);
    assign hit = r_mode_clear ||
                 (col_in && r_row_in && !(r_outline && col_inner && r_row_inner));

    assign wr_en   = uw.wr_cell && !flags.col_end && hit;
    assign wr_addr = r_base + AW'(r_col);
    assign wr_data = r_mode_clear ? r_bg : r_paint;

    // Read address and range check.
    assign rd_lin      = 32'(r_rrow) * 32'(MAX_DIM) + 32'(r_rcol);
    assign rd_addr     = AW'(rd_lin);
    assign rd_in_range = (int'(r_rcol) < MAX_DIM) && (int'(r_rrow) < MAX_DIM);

    // Raster counters, bounds and row flags.
    always_ff @(posedge i_clk) begin
        if (uw.ld_draw || uw.ld_clear) begin
            r_row        <= '0;
            r_col        <= '0;
            r_base       <= '0;
            r_mode_clear <= uw.ld_clear;
        end
        if (uw.ld_draw) begin
            r_outline <= (r_kind == KIND_OUTLINE);
            r_xl      <= GW'(r_x);
            r_xr      <= GW'(r_x) + GW'(r_w);
            r_xil     <= GW'(r_x) + GW'(ONE_UNIT);
            r_xir     <= GW'(r_x) + GW'(r_w) - GW'(ONE_UNIT);
            r_yl      <= GW'(r_y);
            r_yb      <= GW'(r_y) + GW'(r_h);
            r_yil     <= GW'(r_y) + GW'(ONE_UNIT);
            r_yib     <= GW'(r_y) + GW'(r_h) - GW'(ONE_UNIT);
        end
        if (uw.row_flags) begin
            r_row_in    <= (py >= r_yl) && (py <= r_yb);
            r_row_inner <= (py >= r_yil) && (py <= r_yib);
        end
        if (uw.wr_cell && !flags.col_end) begin
            r_col <= r_col + DW'(1);
        end
        if (uw.next_row) begin
            r_col  <= '0;
            r_row  <= r_row + DW'(1);
            r_base <= r_base + AW'(MAX_DIM);
        end
    end

    // Canvas store.
    rrc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (uw.mem_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result strobe and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (uw.emit != EM_NONE);
        end
        unique case (uw.emit)
            EM_REJ: begin
                r_status <= 1'b1;
                r_cell   <= 8'd0;
            end
            EM_READ: begin
                r_status <= 1'b0;
                r_cell   <= rd_in_range ? rd_data : 8'd0;
            end
            default: begin
                r_status <= 1'b0;
                r_cell   <= 8'd0;
            end
        endcase
    end

    // A result strobe always ends a busy period.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // The canvas is written only while a request is in progress.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> busy)
        else $error("canvas write while idle");

    // A taken request always leads into dispatch.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (uw.cond == C_REQ))
        else $error("accepted request did not reach dispatch");

    // A rejected draw carries no character.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_cell_char == 8'd0))
        else $error("rejected draw with a nonzero character");

endmodule

>>> src/rrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> src/rrc_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_useq
// Microcode sequencer: step counter, program ROM and conditional branches.
// ----------------------------------------------------------------------------
module rrc_useq import rrc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uword,
    output logic   o_idle
);

    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    logic             taken;

    assign o_uword = uword(r_pc);
    assign o_idle  = (r_pc == U_IDLE);

    // Evaluate the branch condition of the current step.
    always_comb begin
        unique case (o_uword.cond)
            C_ALWAYS:  taken = 1'b1;
            C_START:   taken = i_flags.start;
            C_REJECT:  taken = i_flags.reject;
            C_ROW_END: taken = i_flags.row_end;
            C_COL_END: taken = i_flags.col_end;
            default:   taken = 1'b1;
        endcase
        if (o_uword.cond == C_REQ) begin
            n_pc = o_uword.tgt_t + UPC_W'(i_flags.req);
        end else if (taken) begin
            n_pc = o_uword.tgt_t;
        end else begin
            n_pc = o_uword.tgt_f;
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle raster canvas.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the canvas and of the size and background
// registers. It predicts the status and cell character of every request when
// the request is taken. It then compares each strobed result against the
// oldest prediction. The run first paints the whole store with a full-size
// clear, so that every later read hits a written cell. A directed part covers
// edge coordinates, both kinds, rejected draws, empty and oversized canvas
// settings, and the unused request code. Random phases follow on small
// canvases with fresh register settings, and each phase begins only after
// all earlier results have drained.
// ----------------------------------------------------------------------------
module testbench import rrc_pkg::*; ();

    localparam int          CANVAS_DIM  = 256;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          SETTLE_CYCLES = 16;

    // One request as the block sees it.
    typedef struct {
        logic [1:0]         req_type;
        logic [7:0]         kind;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] w;
        logic signed [17:0] h;
        logic [7:0]         paint;
        logic [7:0]         col;
        logic [7:0]         row;
    } t_canvas_req;

    typedef struct {
        bit       status;
        bit [7:0] cell_char;
    } t_canvas_result;

    // Canvas scoreboard: predicts each request and checks the results in order.
    class t_canvas_scoreboard;
        bit [7:0]       cells [CANVAS_DIM*CANVAS_DIM];
        bit [8:0]       width_reg;
        bit [8:0]       height_reg;
        bit [7:0]       bg_reg;
        t_canvas_result expected_q [$];
        int             errors;

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            bg_reg     = 8'd32;
            errors     = 0;
        endfunction

        function void note_config(logic [1:0] index, logic [8:0] data);
            case (index)
                CFG_WIDTH:  width_reg  = data;
                CFG_HEIGHT: height_reg = data;
                CFG_BG:     bg_reg     = data[7:0];
                default: ;
            endcase
        endfunction

        // Size registers above the store size act as the store size.
        function int clip_dim(bit [8:0] value);
            return (value > CANVAS_DIM) ? CANVAS_DIM : int'(value);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one taken request to the canvas copy and queue its result.
        function void note_request(t_canvas_req req);
            t_canvas_result res;
            int             cols;
            int             rows;
            int             r;
            int             c;
            longint         x0;
            longint         y0;
            longint         x1;
            longint         y1;
            longint         px;
            longint         py;
            bit             on_border;
            res.status    = 1'b0;
            res.cell_char = 8'd0;
            cols = clip_dim(width_reg);
            rows = clip_dim(height_reg);
            case (req.req_type)
                REQ_DRAW: begin
                    if ((req.kind != KIND_FILLED && req.kind != KIND_OUTLINE) ||
                        req.w <= 0 || req.h <= 0) begin
                        res.status = 1'b1;
                    end else begin
                        x0 = req.x;
                        y0 = req.y;
                        x1 = x0 + req.w;
                        y1 = y0 + req.h;
                        for (r = 0; r < rows; r++) begin
                            py = longint'(r) * ONE_UNIT;
                            if (py < y0 || py > y1) continue;
                            for (c = 0; c < cols; c++) begin
                                px = longint'(c) * ONE_UNIT;
                                if (px < x0 || px > x1) continue;
                                // A cell is on the border unless it is a full
                                // unit inside every edge.
                                on_border = !(px - ONE_UNIT >= x0 && px + ONE_UNIT <= x1 &&
                                              py - ONE_UNIT >= y0 && py + ONE_UNIT <= y1);
                                if (req.kind == KIND_FILLED || on_border)
                                    cells[r*CANVAS_DIM + c] = req.paint;
                            end
                        end
                    end
                end
                REQ_READ: begin
                    res.cell_char = cells[int'(req.row)*CANVAS_DIM + int'(req.col)];
                end
                REQ_CLEAR: begin
                    for (r = 0; r < rows; r++)
                        for (c = 0; c < cols; c++)
                            cells[r*CANVAS_DIM + c] = bg_reg;
                end
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic status, logic [7:0] cell_char);
            t_canvas_result exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: status %b char %02h",
                                 status, cell_char));
                return;
            end
            exp_res = expected_q.pop_front();
            if (status !== exp_res.status)
                report($sformatf("status %b, predicted %b", status, exp_res.status));
            if (cell_char !== exp_res.cell_char)
                report($sformatf("cell char %02h, predicted %02h", cell_char,
                                 exp_res.cell_char));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = '0;
    logic [7:0]         i_rect_kind = '0;
    logic signed [17:0] i_rect_x = '0;
    logic signed [17:0] i_rect_y = '0;
    logic signed [17:0] i_rect_w = '0;
    logic signed [17:0] i_rect_h = '0;
    logic [7:0]         i_paint_char = '0;
    logic [7:0]         i_read_col = '0;
    logic [7:0]         i_read_row = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [8:0]         i_cfg_data = '0;
    logic               o_done;
    logic               o_status;
    logic [7:0]         o_cell_char;

    t_canvas_scoreboard sb;
    bit                 burst = 1'b0;
    int unsigned        cycle_count = 0;

    rectangle_raster_canvas_top #(
        .MAX_DIM (CANVAS_DIM)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_rect_kind  (i_rect_kind),
        .i_rect_x     (i_rect_x),
        .i_rect_y     (i_rect_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .i_paint_char (i_paint_char),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_cell_char  (o_cell_char)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // Result monitor: every strobed result is checked at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result(o_status, o_cell_char);
    end

    function automatic t_canvas_req mk_draw(logic [7:0] kind, int x, int y, int w, int h,
                                            logic [7:0] paint);
        t_canvas_req req;
        req.req_type = REQ_DRAW;
        req.kind     = kind;
        req.x        = 18'(x);
        req.y        = 18'(y);
        req.w        = 18'(w);
        req.h        = 18'(h);
        req.paint    = paint;
        req.col      = 8'($urandom);
        req.row      = 8'($urandom);
        return req;
    endfunction

    function automatic t_canvas_req mk_other(logic [1:0] req_type, int col, int row);
        t_canvas_req req;
        req.req_type = req_type;
        req.kind     = 8'($urandom);
        req.x        = 18'($urandom);
        req.y        = 18'($urandom);
        req.w        = 18'($urandom);
        req.h        = 18'($urandom);
        req.paint    = 8'($urandom);
        req.col      = 8'(col);
        req.row      = 8'(row);
        return req;
    endfunction

    // Origin near the canvas, sometimes on a whole unit, sometimes anywhere.
    function automatic int rand_origin(int span);
        int ipart;
        int frac;
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, 18'h3FFFF)) - 131072;
        ipart = int'($urandom_range(0, span + 4)) - 3;
        frac  = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 255));
        return ipart * ONE_UNIT + frac;
    endfunction

    // Extent mostly positive and canvas sized, with whole units and noise.
    function automatic int rand_extent(int span);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return int'($urandom_range(0, 18'h3FFFF)) - 131072;
        if (pick == 1)
            return int'($urandom_range(1, span + 2)) * ONE_UNIT;
        return int'($urandom_range(1, (span + 3) * ONE_UNIT));
    endfunction

    function automatic t_canvas_req random_request(int cols, int rows);
        int         pick;
        int         k;
        logic [7:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            k = $urandom_range(0, 9);
            kind = (k < 4) ? KIND_FILLED : (k < 8) ? KIND_OUTLINE : 8'($urandom);
            return mk_draw(kind, rand_origin(cols), rand_origin(rows), rand_extent(cols),
                           rand_extent(rows), 8'($urandom));
        end
        if (pick < 85) begin
            if ($urandom_range(0, 4) == 0)
                return mk_other(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255));
            return mk_other(REQ_READ, $urandom_range(0, (cols + 2 > 255) ? 255 : cols + 2),
                            $urandom_range(0, (rows + 2 > 255) ? 255 : rows + 2));
        end
        if (pick < 93)
            return mk_other(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
        if (pick < 96)
            return mk_other(REQ_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
        // Noise: a request with every field random.
        return mk_draw(8'($urandom), int'($urandom), int'($urandom), int'($urandom),
                       int'($urandom), 8'($urandom));
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : int'($urandom_range(0, 18));
    endfunction

    // Present a request, hold it until taken, then idle for the given gap.
    task automatic send_request(t_canvas_req req, int gap);
        @(negedge i_clk);
        i_req_type   = req.req_type;
        i_rect_kind  = req.kind;
        i_rect_x     = req.x;
        i_rect_y     = req.y;
        i_rect_w     = req.w;
        i_rect_h     = req.h;
        i_paint_char = req.paint;
        i_read_col   = req.col;
        i_read_row   = req.row;
        start        = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_request(req);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] index, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.note_config(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // New register settings for a random phase, kept small so draws stay short.
    task automatic random_config();
        int wv;
        int hv;
        case ($urandom_range(0, 9))
            0: begin
                wv = 0;
                hv = $urandom_range(1, 8);
            end
            1: begin
                wv = $urandom_range(257, 511);
                hv = $urandom_range(1, 2);
            end
            2: begin
                wv = $urandom_range(1, 2);
                hv = $urandom_range(257, 511);
            end
            default: begin
                wv = $urandom_range(1, 20);
                hv = $urandom_range(1, 20);
            end
        endcase
        write_reg(CFG_WIDTH, 9'(wv));
        write_reg(CFG_HEIGHT, 9'(hv));
        write_reg(CFG_BG, 9'($urandom_range(0, 255)));
    endtask

    initial begin
        int phase;
        int n;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full-size canvas: the clear writes every cell of the store.
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd256);
        write_reg(CFG_BG, 9'd255);
        send_request(mk_other(REQ_CLEAR, 0, 0), draw_gap());
        send_request(mk_other(REQ_READ, 0, 0), draw_gap());
        send_request(mk_other(REQ_READ, 255, 255), draw_gap());
        send_request(mk_draw(KIND_OUTLINE, 384, -64, 250*256 + 192, 255*256 + 128, 8'h23),
                     draw_gap());
        send_request(mk_other(REQ_READ, 2, 0), draw_gap());
        send_request(mk_draw(KIND_FILLED, -512, 0, 131071, 131071, 8'h00), draw_gap());
        send_request(mk_other(REQ_READ, 255, 255), draw_gap());

        // An empty area, then a width beyond the store size.
        wait_drained();
        write_reg(CFG_WIDTH, 9'd0);
        write_reg(CFG_HEIGHT, 9'd5);
        write_reg(CFG_BG, 9'h041);
        send_request(mk_other(REQ_CLEAR, 0, 0), draw_gap());
        send_request(mk_draw(KIND_FILLED, 0, 0, 2560, 2560, 8'h78), draw_gap());
        send_request(mk_other(REQ_READ, 0, 0), draw_gap());
        wait_drained();
        write_reg(CFG_WIDTH, 9'd511);
        write_reg(CFG_HEIGHT, 9'd1);
        send_request(mk_draw(KIND_FILLED, 0, 0, 131071, 256, 8'hAA), draw_gap());
        send_request(mk_other(REQ_READ, 255, 0), draw_gap());

        // Small canvas: closed edges, outline interior, rejects, unused code.
        wait_drained();
        write_reg(CFG_WIDTH, 9'd12);
        write_reg(CFG_HEIGHT, 9'd9);
        write_reg(CFG_BG, 9'h02E);
        send_request(mk_other(REQ_CLEAR, 0, 0), draw_gap());
        send_request(mk_draw(KIND_FILLED, 512, 256, 1024, 768, 8'h23), draw_gap());
        send_request(mk_other(REQ_READ, 2, 1), draw_gap());
        send_request(mk_other(REQ_READ, 6, 4), draw_gap());
        send_request(mk_draw(KIND_OUTLINE, 0, 0, 11*256, 8*256, 8'h6F), draw_gap());
        send_request(mk_other(REQ_READ, 5, 4), draw_gap());
        send_request(mk_other(REQ_READ, 0, 4), draw_gap());
        send_request(mk_draw(8'h51, 0, 0, 1024, 1024, 8'h01), draw_gap());
        send_request(mk_draw(KIND_FILLED, 0, 0, 0, 1024, 8'h02), draw_gap());
        send_request(mk_draw(KIND_OUTLINE, 0, 0, 1024, -1, 8'h03), draw_gap());
        send_request(mk_draw(KIND_FILLED, 0, 0, -131072, 131071, 8'h04), draw_gap());
        send_request(mk_draw(KIND_FILLED, 131071, -131072, 131071, 131071, 8'h05),
                     draw_gap());
        send_request(mk_other(REQ_UNUSED, 3, 3), draw_gap());
        send_request(mk_other(REQ_READ, 255, 255), draw_gap());

        // Random phases, each on fresh register settings; one runs back to back.
        for (phase = 0; phase < 5; phase++) begin
            wait_drained();
            random_config();
            burst = (phase == 2);
            for (n = 0; n < 15; n++)
                send_request(random_request(sb.clip_dim(sb.width_reg),
                                            sb.clip_dim(sb.height_reg)), draw_gap());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
